// ----- rtl/cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types, sizes and codes of the code point font selector.
// ----------------------------------------------------------------------------
package cfs_pkg;

  // Table geometry
  localparam int FONT_SLOTS      = 4;
  localparam int RANGES_PER_FONT = 16;
  localparam int TABLE_DEPTH     = FONT_SLOTS * RANGES_PER_FONT;
  localparam int TBL_IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths fixed by the interface
  localparam int CP_W        = 21;
  localparam int FSLOT_W     = 2;
  localparam int RSLOT_W     = 4;
  localparam int FIDX_W      = 2;
  localparam int KIND_W      = 3;
  localparam int CNT_W       = 3;
  localparam int MASK_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  // Printable ASCII window
  localparam logic [CP_W-1:0] ASCII_LOW  = CP_W'(32'h20);
  localparam logic [CP_W-1:0] ASCII_HIGH = CP_W'(32'h7E);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FONT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ASCII_INDEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CJK_MASK    = 2'd2;

  // Item opcodes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  // Match kinds
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ASCII    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CJK      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FALLBACK = 3'd4;

  // Range table write request
  typedef struct packed {
    logic               en;
    logic [FSLOT_W-1:0] font_slot;
    logic [RSLOT_W-1:0] range_slot;
    logic [CP_W-1:0]    first;
    logic [CP_W-1:0]    last;
    logic               enable;
  } cfs_wr_t;

endpackage

// ----- rtl/cfs_if.sv -----
// ----------------------------------------------------------------------------
// cfs_if
// Channel interfaces of the code point font selector: item in, result out,
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface cfs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [cfs_pkg::CP_W-1:0]    codepoint;
  logic [cfs_pkg::FSLOT_W-1:0] font_slot;
  logic [cfs_pkg::RSLOT_W-1:0] range_slot;
  logic [cfs_pkg::CP_W-1:0]    entry_first;
  logic [cfs_pkg::CP_W-1:0]    entry_last;
  logic                        entry_enable;

  modport source (output valid, opcode, codepoint, font_slot, range_slot,
                  entry_first, entry_last, entry_enable, input ready);
  modport sink   (input valid, opcode, codepoint, font_slot, range_slot,
                  entry_first, entry_last, entry_enable, output ready);
endinterface

interface cfs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       font_found;
  logic [cfs_pkg::FIDX_W-1:0] font_index;
  logic [cfs_pkg::KIND_W-1:0] match_kind;

  modport source (output valid, font_found, font_index, match_kind, input ready);
  modport sink   (input valid, font_found, font_index, match_kind, output ready);
endinterface

interface cfs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cfs_pkg::CFG_IDX_W-1:0]  index;
  logic [cfs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/cfs_range_table.sv -----
// ----------------------------------------------------------------------------
// cfs_range_table
// Range entry store with one bound comparator pair per entry; registers the
// per-entry hit vector of the code point held in the first stage.
// ----------------------------------------------------------------------------
module cfs_range_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  cfs_pkg::cfs_wr_t                    wr,
  input  logic [cfs_pkg::CP_W-1:0]            cp,
  output logic [cfs_pkg::TABLE_DEPTH-1:0]     hit_r
);

  logic [cfs_pkg::CP_W-1:0]        low_r  [cfs_pkg::TABLE_DEPTH];
  logic [cfs_pkg::CP_W-1:0]        high_r [cfs_pkg::TABLE_DEPTH];
  logic [cfs_pkg::TABLE_DEPTH-1:0] valid_r;
  logic [cfs_pkg::TABLE_DEPTH-1:0] hit_nxt;
  logic                            wr_ok;
  logic [cfs_pkg::TBL_IDX_W-1:0]   wr_idx;

  // Drop writes aimed past the table
  assign wr_ok = wr.en
              && (int'(wr.font_slot) < cfs_pkg::FONT_SLOTS)
              && (int'(wr.range_slot) < cfs_pkg::RANGES_PER_FONT);
  assign wr_idx = cfs_pkg::TBL_IDX_W'(int'(wr.font_slot) * cfs_pkg::RANGES_PER_FONT
                                      + int'(wr.range_slot));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ok) begin
      valid_r[wr_idx] <= wr.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      low_r[wr_idx]  <= wr.first;
      high_r[wr_idx] <= wr.last;
    end
  end

  always_comb begin
    for (int e = 0; e < cfs_pkg::TABLE_DEPTH; e++) begin
      hit_nxt[e] = valid_r[e] && (cp >= low_r[e]) && (cp <= high_r[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

// ----- rtl/codepoint_font_selector_core.sv -----
// ----------------------------------------------------------------------------
// codepoint_font_selector_core
// Picks a font slot for each code point from a loadable table of ranges.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan   one beat per item: a lookup (opcode 0, codepoint) or a range
//             table write (opcode 1, font_slot, range_slot, bounds, enable).
//   out_chan  one result beat per item, in item order; writes return all zero.
//   cfg_chan  register writes (font_count, ascii_font_index, cjk_font_mask),
//             always ready; write only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. The path
//   from the input beat to out_chan.valid runs through four registers, the
//   first loaded at the beat: input register, per-entry range compare,
//   per-font cover OR, priority pick into the output register.
// A table write takes effect at its input beat, so the very next lookup
//   already sees it; earlier lookups already hold their compare result.
// Reset clears all entry valid bits, the pipeline valid bits and the
//   registers (font_count 0, no ASCII font, no CJK font). Bounds are not
//   cleared; an entry is only used once a write has loaded it.
// When the receiver stalls, the whole pipeline holds and in_chan.ready
//   drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module codepoint_font_selector_core (
  input  logic      clk,
  input  logic      rst_n,
  cfs_in_if.sink    in_chan,
  cfs_out_if.source out_chan,
  cfs_cfg_if.sink   cfg_chan
);

  // Configuration registers
  logic [cfs_pkg::CNT_W-1:0]  font_count_r;
  logic [cfs_pkg::CNT_W-1:0]  ascii_idx_r;
  logic [cfs_pkg::MASK_W-1:0] cjk_mask_r;

  // Pipeline
  logic                              adv;
  logic                              in_beat;
  cfs_pkg::cfs_wr_t                  wr;
  logic                              v1_r, v2_r, v3_r, out_valid_r;
  logic                              op1_r, op2_r, op3_r;
  logic [cfs_pkg::CP_W-1:0]          cp1_r;
  logic                              prn2_r, prn3_r;
  logic [cfs_pkg::TABLE_DEPTH-1:0]   hit2_r;
  logic [cfs_pkg::FONT_SLOTS-1:0]    cover_nxt, cover3_r;

  // Output stage
  logic                       found_nxt, found_r;
  logic [cfs_pkg::FIDX_W-1:0] idx_nxt, idx_r;
  logic [cfs_pkg::KIND_W-1:0] kind_nxt, kind_r;

  // Config write; the port never stalls
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_count_r <= '0;
      ascii_idx_r  <= cfs_pkg::CNT_W'(cfs_pkg::FONT_SLOTS);
      cjk_mask_r   <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        cfs_pkg::CFG_FONT_COUNT:  font_count_r <= cfg_chan.data[cfs_pkg::CNT_W-1:0];
        cfs_pkg::CFG_ASCII_INDEX: ascii_idx_r  <= cfg_chan.data[cfs_pkg::CNT_W-1:0];
        cfs_pkg::CFG_CJK_MASK:    cjk_mask_r   <= cfg_chan.data[cfs_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance every stage together whenever the output register is free
  assign adv             = !out_valid_r || out_chan.ready;
  assign in_chan.ready   = adv;
  assign in_beat         = in_chan.valid && adv;

  // Table write rides the input beat
  always_comb begin
    wr.en         = in_beat && (in_chan.opcode == cfs_pkg::OP_WRITE);
    wr.font_slot  = in_chan.font_slot;
    wr.range_slot = in_chan.range_slot;
    wr.first      = in_chan.entry_first;
    wr.last       = in_chan.entry_last;
    wr.enable     = in_chan.entry_enable;
  end

  cfs_range_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .wr    (wr),
    .cp    (cp1_r),
    .hit_r (hit2_r)
  );

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_beat;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // Per-font cover: OR of that font's entry hits
  always_comb begin
    for (int s = 0; s < cfs_pkg::FONT_SLOTS; s++) begin
      cover_nxt[s] = |hit2_r[s*cfs_pkg::RANGES_PER_FONT +: cfs_pkg::RANGES_PER_FONT];
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      op1_r    <= in_chan.opcode;
      cp1_r    <= in_chan.codepoint;
      op2_r    <= op1_r;
      prn2_r   <= (cp1_r >= cfs_pkg::ASCII_LOW) && (cp1_r <= cfs_pkg::ASCII_HIGH);
      op3_r    <= op2_r;
      prn3_r   <= prn2_r;
      cover3_r <= cover_nxt;
      found_r  <= found_nxt;
      idx_r    <= idx_nxt;
      kind_r   <= kind_nxt;
    end
  end

  // Priority pick: ASCII shortcut, first CJK cover, first other cover,
  // ASCII fallback, none
  always_comb begin
    logic                           has_ascii;
    logic                           got_cjk, got_other;
    logic [cfs_pkg::FIDX_W-1:0]     cjk_idx, other_idx;
    logic [cfs_pkg::FONT_SLOTS-1:0] cjk_sel;

    has_ascii = int'(ascii_idx_r) < cfs_pkg::FONT_SLOTS;
    cjk_sel   = cfs_pkg::FONT_SLOTS'(cjk_mask_r);
    got_cjk   = 1'b0;
    got_other = 1'b0;
    cjk_idx   = '0;
    other_idx = '0;
    for (int s = 0; s < cfs_pkg::FONT_SLOTS; s++) begin
      if (!got_cjk && (s < int'(font_count_r)) && cjk_sel[s] && cover3_r[s]) begin
        got_cjk = 1'b1;
        cjk_idx = cfs_pkg::FIDX_W'(s);
      end
      if (!got_other && (s < int'(font_count_r)) && (s != int'(ascii_idx_r))
          && cover3_r[s]) begin
        got_other = 1'b1;
        other_idx = cfs_pkg::FIDX_W'(s);
      end
    end

    found_nxt = 1'b0;
    idx_nxt   = '0;
    kind_nxt  = cfs_pkg::KIND_NONE;
    if (op3_r == cfs_pkg::OP_LOOKUP) begin
      if (prn3_r && has_ascii) begin
        found_nxt = 1'b1;
        idx_nxt   = ascii_idx_r[cfs_pkg::FIDX_W-1:0];
        kind_nxt  = cfs_pkg::KIND_ASCII;
      end else if (got_cjk) begin
        found_nxt = 1'b1;
        idx_nxt   = cjk_idx;
        kind_nxt  = cfs_pkg::KIND_CJK;
      end else if (got_other) begin
        found_nxt = 1'b1;
        idx_nxt   = other_idx;
        kind_nxt  = cfs_pkg::KIND_OTHER;
      end else if (has_ascii) begin
        found_nxt = 1'b1;
        idx_nxt   = ascii_idx_r[cfs_pkg::FIDX_W-1:0];
        kind_nxt  = cfs_pkg::KIND_FALLBACK;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.font_found = found_r;
  assign out_chan.font_index = idx_r;
  assign out_chan.match_kind = kind_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Input only stalls behind a result that is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_valid_r)
    else $error("input stalled with empty output register");

  // A frozen pipeline keeps the stage valid bits ahead of the output register
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v1_r) && $stable(v2_r) && $stable(v3_r))
    else $error("pipeline moved during stall");

  // Found flag agrees with the match kind
  a_found_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (found_r == (kind_r != cfs_pkg::KIND_NONE)))
    else $error("font_found inconsistent with match_kind");

  // ASCII shortcut and fallback name the configured ASCII slot
  a_ascii_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((kind_r == cfs_pkg::KIND_ASCII) || (kind_r == cfs_pkg::KIND_FALLBACK))
    |-> (idx_r == ascii_idx_r[cfs_pkg::FIDX_W-1:0]))
    else $error("ASCII result on wrong slot");

endmodule

// ----- test/codepoint_font_selector_core_tb.sv -----
// ----------------------------------------------------------------------------
// codepoint_font_selector_core_tb
// Self-checking bench for the code point font selector. A table of directed
// beats covers the lookup priority order and the register corner cases; a
// random run follows that loads range entries and looks up code points near
// their bounds. Each result is checked against a pinned value or an in-bench
// font picker, under changing idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module codepoint_font_selector_core_tb;
  import cfs_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SEG_ITEMS    = 58;
  localparam int DIR_ROWS     = 33;
  // Index 3 maps to no register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [CP_W-1:0] CP_TOP = {CP_W{1'b1}};

  typedef struct packed {
    logic              found;
    logic [FIDX_W-1:0] idx;
    logic [KIND_W-1:0] kind;
  } font_pick_t;

  // One row of stimulus: either a register write or one input beat.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  op;
    logic [CP_W-1:0]       cp;
    logic [FSLOT_W-1:0]    fslot;
    logic [RSLOT_W-1:0]    rslot;
    logic [CP_W-1:0]       first;
    logic [CP_W-1:0]       last;
    logic                  en;
    logic                  pinned;
    font_pick_t            want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cfs_in_if  in_ch();
  cfs_out_if out_ch();
  cfs_cfg_if cfg_ch();

  codepoint_font_selector_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_chan (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench copy of the block state: range table and the three registers.
  // --------------------------------------------------------------------------
  logic [CP_W-1:0]        tbl_first [TABLE_DEPTH];
  logic [CP_W-1:0]        tbl_last  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_live;
  logic [CNT_W-1:0]       sh_font_count;
  logic [CNT_W-1:0]       sh_ascii_idx;
  logic [MASK_W-1:0]      sh_cjk_mask;

  font_pick_t font_pick_q[$];
  step_row_t  cur_row;
  step_row_t  plan [DIR_ROWS];

  int errors;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int n_lookups;
  int n_writes;
  int n_reg_writes;
  int n_in_stalls;
  int kind_seen [5];

  // True when one of the slot's live entries spans the code point.
  function automatic bit font_covers(input int slot, input logic [CP_W-1:0] cp);
    int k;
    for (int r = 0; r < RANGES_PER_FONT; r++) begin
      k = slot * RANGES_PER_FONT + r;
      if (tbl_live[k] && cp >= tbl_first[k] && cp <= tbl_last[k]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Priority order: ASCII shortcut, CJK cover, other cover, ASCII fallback.
  function automatic font_pick_t pick_font(input logic [CP_W-1:0] cp);
    int n;
    bit has_ascii;
    n = (sh_font_count > FONT_SLOTS) ? FONT_SLOTS : int'(sh_font_count);
    has_ascii = sh_ascii_idx < FONT_SLOTS;
    if (cp >= ASCII_LOW && cp <= ASCII_HIGH && has_ascii)
      return '{1'b1, sh_ascii_idx[FIDX_W-1:0], KIND_ASCII};
    for (int i = 0; i < n; i++)
      if (sh_cjk_mask[i] && font_covers(i, cp)) return '{1'b1, FIDX_W'(i), KIND_CJK};
    for (int i = 0; i < n; i++)
      if (i != int'(sh_ascii_idx) && font_covers(i, cp))
        return '{1'b1, FIDX_W'(i), KIND_OTHER};
    if (has_ascii) return '{1'b1, sh_ascii_idx[FIDX_W-1:0], KIND_FALLBACK};
    return '{1'b0, '0, KIND_NONE};
  endfunction

  // --------------------------------------------------------------------------
  // Row builders for the directed table.
  // --------------------------------------------------------------------------
  function automatic step_row_t row_look(input logic [CP_W-1:0] cp);
    step_row_t r;
    r = '0;
    r.op = OP_LOOKUP;
    r.cp = cp;
    return r;
  endfunction

  function automatic step_row_t row_pin(input logic [CP_W-1:0] cp, input logic found,
                                        input logic [FIDX_W-1:0] idx,
                                        input logic [KIND_W-1:0] kind);
    step_row_t r;
    r = row_look(cp);
    r.pinned = 1'b1;
    r.want = '{found, idx, kind};
    return r;
  endfunction

  // A table write always returns an all-zero result.
  function automatic step_row_t row_wr(input logic [FSLOT_W-1:0] fs,
                                       input logic [RSLOT_W-1:0] rs,
                                       input logic [CP_W-1:0] first,
                                       input logic [CP_W-1:0] last, input logic en);
    step_row_t r;
    r = '0;
    r.op = OP_WRITE;
    r.fslot = fs;
    r.rslot = rs;
    r.first = first;
    r.last = last;
    r.en = en;
    r.pinned = 1'b1;
    r.want = '{1'b0, '0, KIND_NONE};
    return r;
  endfunction

  function automatic step_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    step_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_data = data;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus. Lookups lean on ASCII, the CJK block and the bounds of
  // entries already loaded, so every priority branch is hit often.
  // --------------------------------------------------------------------------
  function automatic logic [CP_W-1:0] rand_codepoint();
    int k;
    logic [CP_W-1:0] base;
    case ($urandom_range(0, 9))
      0, 1: return CP_W'($urandom_range(32'h1E, 32'h80));
      2, 3: begin
        k = $urandom_range(0, TABLE_DEPTH - 1);
        base = $urandom_range(0, 1) ? tbl_first[k] : tbl_last[k];
        return base + CP_W'($urandom_range(0, 2)) - CP_W'(1);
      end
      4: return CP_W'($urandom_range(32'h4E00, 32'h9FFF));
      5, 6: return CP_W'($urandom_range(0, 32'hFFFF));
      default: return CP_W'($urandom_range(0, 32'h1FFFFF));
    endcase
  endfunction

  function automatic step_row_t rand_item();
    step_row_t r;
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    int span;
    r = '0;
    if ($urandom_range(0, 99) >= 35) begin
      r.op = OP_LOOKUP;
      r.cp = rand_codepoint();
      return r;
    end
    r.op = OP_WRITE;
    r.fslot = FSLOT_W'($urandom_range(0, FONT_SLOTS - 1));
    r.rslot = RSLOT_W'($urandom_range(0, RANGES_PER_FONT - 1));
    lo = rand_codepoint();
    span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32'h1FFFFF)
                                       : $urandom_range(0, 32'h3000);
    hi = (32'(lo) + span > 32'h1FFFFF) ? CP_TOP : CP_W'(32'(lo) + span);
    // Swap now and then to get empty ranges.
    if ($urandom_range(0, 9) == 0) begin
      r.first = hi;
      r.last = lo;
    end else begin
      r.first = lo;
      r.last = hi;
    end
    r.en = ($urandom_range(0, 99) < 85);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge only.
  // --------------------------------------------------------------------------
  task automatic push_item(input step_row_t row);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    cur_row = row;
    in_ch.opcode = row.op;
    in_ch.codepoint = row.cp;
    in_ch.font_slot = row.fslot;
    in_ch.range_slot = row.rslot;
    in_ch.entry_first = row.first;
    in_ch.entry_last = row.last;
    in_ch.entry_enable = row.en;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result is back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (font_pick_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data = data;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Mostly sensible settings, with the full data range now and then.
  task automatic shuffle_regs();
    wait_drained();
    write_reg(CFG_FONT_COUNT, ($urandom_range(0, 99) < 80) ? CFG_DATA_W'($urandom_range(1, 4))
                                                           : CFG_DATA_W'($urandom_range(0, 15)));
    write_reg(CFG_ASCII_INDEX, ($urandom_range(0, 99) < 70) ? CFG_DATA_W'($urandom_range(0, 3))
                                                            : CFG_DATA_W'($urandom_range(0, 15)));
    write_reg(CFG_CJK_MASK, CFG_DATA_W'($urandom_range(0, 15)));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 15)));
  endtask

  // Receiver: random idling, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: update the bench state on accepted beats, predict, and check.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    font_pick_t got;
    font_pick_t want;
    int k;
    if (!rst_n) begin
      tbl_live = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        tbl_first[i] = '0;
        tbl_last[i] = '0;
      end
      sh_font_count = '0;
      sh_ascii_idx = CNT_W'(FONT_SLOTS);
      sh_cjk_mask = '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        n_reg_writes++;
        case (cfg_ch.index)
          CFG_FONT_COUNT:  sh_font_count = cfg_ch.data[CNT_W-1:0];
          CFG_ASCII_INDEX: sh_ascii_idx = cfg_ch.data[CNT_W-1:0];
          CFG_CJK_MASK:    sh_cjk_mask = cfg_ch.data[MASK_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && !in_ch.ready) n_in_stalls++;

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_WRITE) begin
          // The write is visible to the very next lookup.
          k = int'(in_ch.font_slot) * RANGES_PER_FONT + int'(in_ch.range_slot);
          tbl_first[k] = in_ch.entry_first;
          tbl_last[k] = in_ch.entry_last;
          tbl_live[k] = in_ch.entry_enable;
          n_writes++;
          want = '{1'b0, '0, KIND_NONE};
        end else begin
          n_lookups++;
          want = pick_font(in_ch.codepoint);
        end
        font_pick_q.push_back(cur_row.pinned ? cur_row.want : want);
      end

      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.font_found, out_ch.font_index, out_ch.match_kind};
        if (got.kind < 5) kind_seen[got.kind]++;
        if (font_pick_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: found %0d idx %0d kind %0d",
                   $time, got.found, got.idx, got.kind);
          errors++;
        end else begin
          want = font_pick_q.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: font_found expected %0d actual %0d", $time, want.found, got.found);
            errors++;
          end
          if (got.idx !== want.idx) begin
            $display("%0t: font_index expected %0d actual %0d", $time, want.idx, got.idx);
            errors++;
          end
          if (got.kind !== want.kind) begin
            $display("%0t: match_kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on a plain cycle count.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still expected", $time, font_pick_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    errors = 0;
    cycles = 0;
    hold_left = 0;
    n_lookups = 0;
    n_writes = 0;
    n_reg_writes = 0;
    n_in_stalls = 0;
    for (int i = 0; i < 5; i++) kind_seen[i] = 0;
    send_idle_pct = 7;
    recv_idle_pct = 65;

    rst_n = 1'b0;
    cur_row = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOOKUP;
    in_ch.codepoint = '0;
    in_ch.font_slot = '0;
    in_ch.range_slot = '0;
    in_ch.entry_first = '0;
    in_ch.entry_last = '0;
    in_ch.entry_enable = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_FONT_COUNT;
    cfg_ch.data = '0;

    // Directed table. Slot 0 holds printable ASCII, slot 1 the CJK block,
    // slot 2 the whole 21-bit space, slot 3 an empty (reversed) range.
    plan = '{
      row_pin('h41, 1'b0, 2'd0, KIND_NONE),          // reset: no fonts at all
      row_wr(2'd0, 4'd0, 'h20, 'h7E, 1'b1),
      row_wr(2'd1, 4'd0, 'h4E00, 'h9FFF, 1'b1),
      row_wr(2'd2, 4'd15, 'h0, CP_TOP, 1'b1),
      row_wr(2'd3, 4'd7, 'h500, 'h400, 1'b1),
      row_cfg(CFG_FONT_COUNT, 4'd4),
      row_cfg(CFG_ASCII_INDEX, 4'd0),
      row_cfg(CFG_CJK_MASK, 4'd2),
      row_pin('h20, 1'b1, 2'd0, KIND_ASCII),         // low edge of shortcut
      row_pin('h7E, 1'b1, 2'd0, KIND_ASCII),         // high edge of shortcut
      row_look('h1F),
      row_look('h7F),
      row_pin('h4E00, 1'b1, 2'd1, KIND_CJK),
      row_look(CP_TOP),                              // beyond Unicode
      row_look('h450),                               // inside the empty range
      row_wr(2'd2, 4'd15, 'h0, CP_TOP, 1'b0),        // clear the catch-all
      row_pin('h450, 1'b1, 2'd0, KIND_FALLBACK),
      row_look('h9FFF),
      row_cfg(CFG_FONT_COUNT, 4'd7),                 // count above slot total
      row_cfg(CFG_ASCII_INDEX, 4'd7),                // no ASCII font
      row_cfg(CFG_CJK_MASK, 4'd15),
      row_look('h41),
      row_pin('h0, 1'b0, 2'd0, KIND_NONE),
      row_cfg(CFG_FONT_COUNT, 4'd1),
      row_cfg(CFG_ASCII_INDEX, 4'd3),                // ASCII slot past the count
      row_cfg(CFG_CJK_MASK, 4'd0),
      row_pin('h41, 1'b1, 2'd3, KIND_ASCII),
      row_pin('h4E00, 1'b1, 2'd3, KIND_FALLBACK),
      row_cfg(CFG_FONT_COUNT, 4'd0),
      row_cfg(CFG_ASCII_INDEX, 4'd4),
      row_pin('h41, 1'b0, 2'd0, KIND_NONE),
      row_cfg(CFG_SPARE, 4'd15),                     // unmapped index
      row_pin('h7E, 1'b0, 2'd0, KIND_NONE)
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_reg(plan[i].cfg_idx, plan[i].cfg_data);
      end else begin
        push_item(plan[i]);
      end
    end

    // Random run in three idle patterns, four register settings each.
    for (int phase = 0; phase < 3; phase++) begin
      wait_drained();
      send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 7 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        shuffle_regs();
        for (int n = 0; n < SEG_ITEMS; n++) begin
          // Stall the output long enough to back up the whole pipeline.
          if (phase == 2 && seg == 1 && n == 10) hold_left = 300;
          push_item(rand_item());
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d lookups and %0d table writes with %0d register writes;",
             n_lookups, n_writes, n_reg_writes);
    $display("kinds none/ascii/cjk/other/fallback %0d/%0d/%0d/%0d/%0d, %0d input stall cycles",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             n_in_stalls);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
